// File: sv/remc_pkg.sv
// Shared types, codes and reset values for the rotary encoder mode control.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package remc_pkg;

  // Register map, indexed by paddr[3:2]
  typedef enum logic [1:0] {
    REG_TICKS_PER_UNIT = 2'd0,
    REG_SHORT_ABOVE    = 2'd1,
    REG_SHORT_BELOW    = 2'd2,
    REG_LONG_ABOVE     = 2'd3
  } reg_idx_e;

  // Step direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_e;

  // Step target codes
  localparam logic TGT_STREAM = 1'b0;
  localparam logic TGT_TUNER  = 1'b1;

  // Mode change messages
  typedef enum logic [1:0] {
    MSG_NONE      = 2'd0,
    MSG_TO_TUNER  = 2'd1,
    MSG_TO_STREAM = 2'd2,
    MSG_STANDBY   = 2'd3
  } msg_e;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_STREAM  = 2'd0,
    MODE_TUNER   = 2'd1,
    MODE_STANDBY = 2'd2
  } mode_e;

  localparam int unsigned TpuW   = 16;
  localparam int unsigned UnitsW = 8;

  localparam logic [TpuW-1:0]   TPU_RST         = 16'd10;
  localparam logic [UnitsW-1:0] SHORT_ABOVE_RST = 8'd5;
  localparam logic [UnitsW-1:0] SHORT_BELOW_RST = 8'd12;
  localparam logic [UnitsW-1:0] LONG_ABOVE_RST  = 8'd25;
  localparam logic [UnitsW-1:0] UNITS_MAX       = 8'd255;

  // Input sample, lowest bit first: pin_a, pin_b, pin_switch, pad
  typedef struct packed {
    logic [4:0] pad;
    logic       pin_switch;
    logic       pin_b;
    logic       pin_a;
  } sample_t;

  // Result item, lowest bit first: step_dir, step_target, mode_msg, mode_now, power_on
  typedef struct packed {
    logic       power_on;
    logic [1:0] mode_now;
    logic [1:0] mode_msg;
    logic       step_target;
    logic [1:0] step_dir;
  } result_t;

endpackage

`default_nettype wire

// File: sv/rotary_encoder_mode_control.sv
// Rotary encoder decoder and push-switch mode controller, top level.
// Depends on remc_pkg.
//
// Usage:
//   The input stream carries one pin sample per tick on s_axis (tdata bit 0
//   pin_a, bit 1 pin_b, bit 2 pin_switch). Every accepted sample produces
//   exactly one result on m_axis: encoder step and its target, a mode change
//   message, the mode after this sample and the audio power drive.
//   A sample taken at one edge shows its result on m_axis right after that
//   edge. Throughput is one sample per cycle while the receiver keeps up; the
//   decode and press-timer update is a single pass of comparators and two
//   small counters between the input port and the result register.
//   When the receiver stalls, the result register holds its item and
//   s_axis_tready_o stays high only if that item is taken in the same cycle,
//   so no result is dropped and no sample is lost.
//   Reset (rst_ni low) puts the block in stream mode with power on, clears
//   the encoder latch and press timer, empties the result register and loads
//   the register defaults. Registers are written over the APB port at byte
//   addresses 0, 4, 8, 12 (ticks_per_unit, short_above, short_below, long_above);
//   the user must write them only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_mode_control (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // pin_a, pin_b, pin_switch, zero pad
  // result stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o,   // step_dir[1:0], step_target, mode_msg[1:0],
                                             // mode_now[1:0], power_on
  // configuration
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [3:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output      logic [31:0] prdata_o,
  output      logic        pready_o
);
  import remc_pkg::*;

  // Configuration registers
  logic [TpuW-1:0]   tpu_q;
  logic [UnitsW-1:0] short_above_q, short_below_q, long_above_q;

  // Block state
  mode_e             mode_q, mode_d;
  logic              power_q, power_d;
  logic              a_low_q, a_low_d;
  logic              first_b_q, first_b_d;
  logic              latest_b_q, latest_b_d;
  logic [UnitsW-1:0] units_q, units_d;
  logic [TpuW-1:0]   prescale_q, prescale_d;

  // Result register
  logic              out_valid_q;
  result_t           out_q, out_d;

  sample_t           smp;
  logic              in_xfer;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;
  logic [TpuW-1:0]   prescale_inc;
  mode_e             mode_mid;
  dir_e              dir;
  msg_e              msg;

  assign smp      = sample_t'(s_axis_tdata_i);
  assign cfg_idx  = reg_idx_e'(paddr_i[3:2]);
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  // Accept a sample whenever the result slot is free or drains this cycle
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Register readback
  always_comb begin
    prdata_o = '0;
    unique case (cfg_idx)
      REG_TICKS_PER_UNIT: prdata_o = {16'd0, tpu_q};
      REG_SHORT_ABOVE:    prdata_o = {24'd0, short_above_q};
      REG_SHORT_BELOW:    prdata_o = {24'd0, short_below_q};
      REG_LONG_ABOVE:     prdata_o = {24'd0, long_above_q};
      default:            prdata_o = '0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q         <= TPU_RST;
      short_above_q <= SHORT_ABOVE_RST;
      short_below_q <= SHORT_BELOW_RST;
      long_above_q  <= LONG_ABOVE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TICKS_PER_UNIT: tpu_q         <= pwdata_i[TpuW-1:0];
        REG_SHORT_ABOVE:    short_above_q <= pwdata_i[UnitsW-1:0];
        REG_SHORT_BELOW:    short_below_q <= pwdata_i[UnitsW-1:0];
        REG_LONG_ABOVE:     long_above_q  <= pwdata_i[UnitsW-1:0];
        default: ;
      endcase
    end
  end

  // Encoder: latch B while A is low, judge the change when A returns high
  always_comb begin
    a_low_d    = a_low_q;
    first_b_d  = first_b_q;
    latest_b_d = latest_b_q;
    dir        = DIR_NONE;
    if (!smp.pin_a) begin
      if (!a_low_q) first_b_d = smp.pin_b;
      latest_b_d = smp.pin_b;
      a_low_d    = 1'b1;
    end else if (a_low_q) begin
      a_low_d = 1'b0;
      if (!first_b_q && latest_b_q) begin
        dir = DIR_FWD;
      end else if (first_b_q && !latest_b_q) begin
        dir = DIR_BWD;
      end
    end
  end

  // Switch: count press units while held, judge them on release
  assign prescale_inc = prescale_q + 1'b1;

  always_comb begin
    prescale_d = prescale_q;
    units_d    = units_q;
    mode_mid   = mode_q;
    mode_d     = mode_q;
    power_d    = power_q;
    msg        = MSG_NONE;
    if (!smp.pin_switch) begin
      prescale_d = prescale_inc;
      if (prescale_inc >= tpu_q) begin
        prescale_d = '0;
        if (units_q != UNITS_MAX) units_d = units_q + 1'b1;
      end
    end else begin
      // source toggle first, then the standby toggle on top of it
      if ((units_q > short_above_q) && (units_q < short_below_q)) begin
        if (mode_q == MODE_STREAM) begin
          mode_mid = MODE_TUNER;
          msg      = MSG_TO_TUNER;
        end else begin
          mode_mid = MODE_STREAM;
          msg      = MSG_TO_STREAM;
        end
        power_d = 1'b1;
      end
      mode_d = mode_mid;
      if (units_q > long_above_q) begin
        if (mode_mid != MODE_STANDBY) begin
          mode_d  = MODE_STANDBY;
          msg     = MSG_STANDBY;
          power_d = 1'b0;
        end else begin
          mode_d  = MODE_STREAM;
          msg     = MSG_TO_STREAM;
          power_d = 1'b1;
        end
      end
      units_d    = '0;
      prescale_d = '0;
    end
  end

  // Assemble the result; target uses the mode before this sample
  always_comb begin
    out_d.step_dir    = dir;
    out_d.step_target = (dir != DIR_NONE && mode_q != MODE_STREAM) ? TGT_TUNER : TGT_STREAM;
    out_d.mode_msg    = msg;
    out_d.mode_now    = mode_d;
    out_d.power_on    = power_d;
  end

  // Advance state on each sample transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_STREAM;
      power_q    <= 1'b1;
      a_low_q    <= 1'b0;
      first_b_q  <= 1'b0;
      latest_b_q <= 1'b0;
      units_q    <= '0;
      prescale_q <= '0;
    end else if (in_xfer) begin
      mode_q     <= mode_d;
      power_q    <= power_d;
      a_low_q    <= a_low_d;
      first_b_q  <= first_b_d;
      latest_b_q <= latest_b_d;
      units_q    <= units_d;
      prescale_q <= prescale_d;
    end
  end

  // Result register: load on input transfer, drop on output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) out_q <= out_d;
  end

endmodule

`default_nettype wire

// File: sv/remc_checker.sv
// Port-level checker for rotary_encoder_mode_control, bound to the top level.
// Depends on remc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module remc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);
  import remc_pkg::*;

  result_t res;
  assign res = result_t'(m_axis_tdata_o);

  // A stalled result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // An empty result slot never blocks the sample stream
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("sample stream blocked with empty result slot");

  // Power follows standby
  a_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res.power_on == (res.mode_now != MODE_STANDBY)))
    else $error("power drive disagrees with mode");

  // A standby message leaves the block in standby; a target needs a step
  a_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.mode_msg == MSG_STANDBY |-> res.mode_now == MODE_STANDBY)
    else $error("standby message without standby mode");

  a_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.step_dir == DIR_NONE |-> res.step_target == TGT_STREAM)
    else $error("step target without step");

endmodule

bind rotary_encoder_mode_control remc_checker u_remc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// File: sim/remc_result_checker.sv
// Result checker for the rotary encoder mode control: watches the sample,
// result and APB channels, predicts every result and compares it.
// Depends on remc_pkg.
`timescale 1ns / 1ps

module remc_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import remc_pkg::*;

  // Register copy
  logic [TpuW-1:0]   tpu_q;
  logic [UnitsW-1:0] short_above_q;
  logic [UnitsW-1:0] short_below_q;
  logic [UnitsW-1:0] long_above_q;

  // Controller state copy
  mode_e             mode_q;
  logic              power_q;
  logic              a_low_q;
  logic              first_b_q;
  logic              latest_b_q;
  logic [UnitsW-1:0] units_q;
  logic [TpuW-1:0]   prescale_q;

  result_t     due_results[$];
  int unsigned n_errors;
  int unsigned n_checked;

  // Advance the controller copy by one pin sample and return its result
  function automatic result_t decode_sample(sample_t smp);
    result_t res;
    dir_e    dir;
    logic    tgt;
    msg_e    msg;
    dir = DIR_NONE;
    tgt = TGT_STREAM;
    msg = MSG_NONE;

    // Encoder: latch B while A is low, judge on the rising A
    if (!smp.pin_a) begin
      if (!a_low_q) first_b_q = smp.pin_b;
      latest_b_q = smp.pin_b;
      a_low_q    = 1'b1;
    end else if (a_low_q) begin
      a_low_q = 1'b0;
      if (!first_b_q && latest_b_q) dir = DIR_FWD;
      else if (first_b_q && !latest_b_q) dir = DIR_BWD;
      if (dir != DIR_NONE) tgt = (mode_q == MODE_STREAM) ? TGT_STREAM : TGT_TUNER;
    end

    // Switch: count units while pressed, judge the press on release
    if (!smp.pin_switch) begin
      prescale_q = prescale_q + 1'b1;
      if (prescale_q >= tpu_q) begin
        prescale_q = '0;
        if (units_q != UNITS_MAX) units_q = units_q + 1'b1;
      end
    end else begin
      if (units_q > short_above_q && units_q < short_below_q) begin
        if (mode_q == MODE_STREAM) begin
          mode_q = MODE_TUNER;
          msg    = MSG_TO_TUNER;
        end else begin
          mode_q = MODE_STREAM;
          msg    = MSG_TO_STREAM;
        end
        power_q = 1'b1;
      end
      if (units_q > long_above_q) begin
        if (mode_q != MODE_STANDBY) begin
          mode_q  = MODE_STANDBY;
          msg     = MSG_STANDBY;
          power_q = 1'b0;
        end else begin
          mode_q  = MODE_STREAM;
          msg     = MSG_TO_STREAM;
          power_q = 1'b1;
        end
      end
      units_q    = '0;
      prescale_q = '0;
    end

    res.step_dir    = dir;
    res.step_target = tgt;
    res.mode_msg    = msg;
    res.mode_now    = mode_q;
    res.power_on    = power_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t     got;
    result_t     want;
    logic [31:0] reg_val;
    if (!rst_ni) begin
      tpu_q         = TPU_RST;
      short_above_q = SHORT_ABOVE_RST;
      short_below_q = SHORT_BELOW_RST;
      long_above_q  = LONG_ABOVE_RST;
      mode_q        = MODE_STREAM;
      power_q       = 1'b1;
      a_low_q       = 1'b0;
      first_b_q     = 1'b0;
      latest_b_q    = 1'b0;
      units_q       = '0;
      prescale_q    = '0;
      due_results.delete();
      n_errors      = 0;
      n_checked     = 0;
    end else begin
      // Compare each result transfer with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i);
        if (due_results.size() == 0) begin
          if (n_errors < 10)
            $display("%0t: result with none due: tdata=%h", $time, m_tdata_i);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (got.step_dir != want.step_dir || got.step_target != want.step_target ||
              got.mode_msg != want.mode_msg || got.mode_now != want.mode_now ||
              got.power_on != want.power_on) begin
            if (n_errors < 10) begin
              $display("%0t: result mismatch: expected dir=%0d tgt=%0d msg=%0d mode=%0d pwr=%0d",
                       $time, want.step_dir, want.step_target, want.mode_msg,
                       want.mode_now, want.power_on);
              $display("%0t:                  got dir=%0d tgt=%0d msg=%0d mode=%0d pwr=%0d",
                       $time, got.step_dir, got.step_target, got.mode_msg,
                       got.mode_now, got.power_on);
            end
            n_errors++;
          end
        end
      end

      // Predict from each sample transfer
      if (s_tvalid_i && s_tready_i) due_results.push_back(decode_sample(sample_t'(s_tdata_i)));

      // Track register writes and check register reads
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (reg_idx_e'(paddr_i[3:2]))
            REG_TICKS_PER_UNIT: tpu_q         = pwdata_i[TpuW-1:0];
            REG_SHORT_ABOVE:    short_above_q = pwdata_i[UnitsW-1:0];
            REG_SHORT_BELOW:    short_below_q = pwdata_i[UnitsW-1:0];
            REG_LONG_ABOVE:     long_above_q  = pwdata_i[UnitsW-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_e'(paddr_i[3:2]))
            REG_TICKS_PER_UNIT: reg_val = {16'd0, tpu_q};
            REG_SHORT_ABOVE:    reg_val = {24'd0, short_above_q};
            REG_SHORT_BELOW:    reg_val = {24'd0, short_below_q};
            default:            reg_val = {24'd0, long_above_q};
          endcase
          if (prdata_i != reg_val) begin
            if (n_errors < 10)
              $display("%0t: register read at %h: expected %h, got %h",
                       $time, paddr_i, reg_val, prdata_i);
            n_errors++;
          end
        end
      end
    end
    err_count_o <= n_errors;
    pending_o   <= due_results.size();
    checked_o   <= n_checked;
  end

endmodule

// File: sim/rotary_encoder_mode_control_tb.sv
// Testbench top for the rotary encoder mode control: drives pin samples,
// random stalls and register settings, and reports the verdict.
// Depends on remc_pkg, remc_result_checker and the block itself.
`timescale 1ns / 1ps

module rotary_encoder_mode_control_tb;
  import remc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;

  // Stimulus bookkeeping
  logic        no_idle;
  int unsigned n_sent;
  int unsigned n_settings;
  logic [15:0] tpu_cur;
  logic [7:0]  sa_cur;
  logic [7:0]  sb_cur;
  logic [7:0]  la_cur;

  rotary_encoder_mode_control DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // pin_a, pin_b, pin_switch, zero pad
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // step_dir[1:0], step_target, mode_msg[1:0],
                                  // mode_now[1:0], power_on
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  remc_result_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // 50 MHz clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 29);
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Send one pin sample, with a random gap ahead of it
  task automatic send_sample(input logic a, input logic b, input logic sw);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, sw, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  // One encoder detent: A low with B held, B possibly moved, then A high
  task automatic send_detent();
    logic        b_lvl;
    int unsigned n_first;
    int unsigned n_moved;
    int unsigned n_high;
    b_lvl   = 1'($urandom_range(0, 1));
    n_first = $urandom_range(1, 3);
    n_moved = $urandom_range(0, 3);
    n_high  = $urandom_range(1, 2);
    repeat (n_first) send_sample(1'b0, b_lvl, 1'b1);
    if ($urandom_range(0, 3) != 0) b_lvl = ~b_lvl;
    repeat (n_moved) send_sample(1'b0, b_lvl, 1'b1);
    repeat (n_high) send_sample(1'b1, 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Hold the switch for a number of ticks while the encoder wanders, then release
  task automatic send_press(input int unsigned ticks);
    logic a_w;
    logic b_w;
    a_w = 1'($urandom_range(0, 1));
    b_w = 1'($urandom_range(0, 1));
    repeat (ticks) begin
      send_sample(a_w, b_w, 1'b0);
      if ($urandom_range(0, 4) == 0) a_w = ~a_w;
      if ($urandom_range(0, 4) == 0) b_w = ~b_w;
    end
    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Mix of detents, presses near the window edges, and raw noise
  task automatic run_gestures(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned units;
    int unsigned tpu_eff;
    start   = n_sent;
    tpu_eff = (tpu_cur == 16'd0) ? 1 : 32'(tpu_cur);
    while (n_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_detent();
      end else if (pick < 80) begin
        case ($urandom_range(0, 7))
          0:       units = 32'(sa_cur);
          1:       units = sa_cur + 1;
          2:       units = (sb_cur == 0) ? 0 : sb_cur - 1;
          3:       units = 32'(sb_cur);
          4:       units = 32'(la_cur);
          5:       units = la_cur + 1;
          6:       units = (tpu_eff <= 2) ? $urandom_range(254, 260) : $urandom_range(0, 8);
          default: units = $urandom_range(0, 8);
        endcase
        if (units * tpu_eff > 800) units = $urandom_range(0, 8);
        send_press(units * tpu_eff + $urandom_range(0, tpu_eff - 1));
      end else begin
        repeat ($urandom_range(1, 5))
          send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
    end
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait for every predicted result to come back
  task automatic drain_results();
    int unsigned guard;
    s_tvalid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Program all four registers and read them back
  task automatic load_settings(input logic [15:0] tpu, input logic [7:0] sa,
                               input logic [7:0] sb, input logic [7:0] la);
    tpu_cur = tpu;
    sa_cur  = sa;
    sb_cur  = sb;
    la_cur  = la;
    apb_access(1'b1, REG_TICKS_PER_UNIT, {16'd0, tpu});
    apb_access(1'b1, REG_SHORT_ABOVE, {24'd0, sa});
    apb_access(1'b1, REG_SHORT_BELOW, {24'd0, sb});
    apb_access(1'b1, REG_LONG_ABOVE, {24'd0, la});
    apb_access(1'b0, REG_TICKS_PER_UNIT, 32'd0);
    apb_access(1'b0, REG_SHORT_ABOVE, 32'd0);
    apb_access(1'b0, REG_SHORT_BELOW, 32'd0);
    apb_access(1'b0, REG_LONG_ABOVE, 32'd0);
    n_settings++;
  endtask

  initial begin
    s_tvalid   <= 1'b0;
    s_tdata    <= 8'd0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= 4'd0;
    pwdata     <= 32'd0;
    rst_n      <= 1'b0;
    no_idle     = 1'b0;
    n_sent      = 0;
    n_settings  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero ticks per unit counts one unit per pressed tick
    load_settings(16'd0, 8'd1, 8'd4, 8'd5);
    // forward step to the stream player
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1);
    // backward step during a 3-unit press, release toggles to tuner
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b1);
    // A pulse with B unchanged gives no step
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1);
    // forward step to the tuner, then a 6-unit press enters standby
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
    // backward step in standby, short press leaves standby for stream
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b1);
    // release with no units, then a press right at the lower bound
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
    drain_results();

    // Random phases over several register settings
    load_settings(TPU_RST, SHORT_ABOVE_RST, SHORT_BELOW_RST, LONG_ABOVE_RST);
    run_gestures(170);
    drain_results();
    // both windows at once
    load_settings(16'd1, 8'd0, 8'd255, 8'd0);
    run_gestures(170);
    drain_results();
    // windows that no press can reach
    load_settings(16'd3, 8'd255, 8'd0, 8'd255);
    run_gestures(150);
    drain_results();
    load_settings(16'd2, 8'd3, 8'd8, 8'd12);
    run_gestures(170);
    drain_results();
    repeat (2) begin
      load_settings(16'($urandom_range(1, 4)), 8'($urandom_range(0, 10)),
                    8'($urandom_range(0, 16)), 8'($urandom_range(0, 30)));
      run_gestures(160);
      drain_results();
    end

    // Widest prescaler with no idling on either side: a long press stays below one unit
    load_settings(16'hFFFF, 8'd0, 8'd2, 8'd255);
    no_idle = 1'b1;
    send_press($urandom_range(100, 150));
    repeat (4) send_detent();
    send_press($urandom_range(1, 20));
    drain_results();
    no_idle = 1'b0;

    $display("Run covered %0d pin samples over %0d register settings, %0d results checked.",
             n_sent, n_settings, checked);
    $display("Included steps in every mode, source and standby toggles, and saturated presses.");
    if (err_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/remc_pkg.sv
sv/rotary_encoder_mode_control.sv
sv/remc_checker.sv
sim/remc_result_checker.sv
sim/rotary_encoder_mode_control_tb.sv
